// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_CLK(label, !(expr), msg)

`endif

// ----- rtl/core/tdds_pkg.sv -----
// ----------------------------------------------------------------------------
// tdds_pkg
// Shared types and constants of the two stage divider search block.
// ----------------------------------------------------------------------------
package tdds_pkg;

	// Width of rates and of the shared divider.
	localparam int RATE_W = 32;

	// Default search ranges.
	localparam int MAIN_BITS_DEF = 4;
	localparam int FINE_BITS_DEF = 8;

	// Output field widths.
	localparam int MAIN_OUT_W = 5;
	localparam int FINE_OUT_W = 8;

	// Source rate after reset, in hertz.
	localparam logic [RATE_W-1:0] SOURCE_RATE_RST = 32'd400000000;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QUO,
		ST_FINE,
		ST_RATE,
		ST_DONE
	} tdds_state_t;

	// Status of the shared divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/core/two_stage_divider_search.sv -----
// ----------------------------------------------------------------------------
// two_stage_divider_search
// Picks a main and a fine divisor that bring the source rate down to the
// nearest rate not above the target. Start takes a word when busy is low;
// a target of zero, or a source rate of zero, gives not found, and a target
// not below the source gives main 1 and fine 1, both with done in the cycle
// after start. Otherwise every main divisor 1..2^MAIN_BITS is tried with
// three 32-bit divisions on one shared bit-serial divider.
// Done is high for one cycle with found, main_divisor and fine_divisor; the
// receiver cannot stall it, and busy stays high until the cycle after done.
// Source_rate is written through source_rate_we; the user must write it
// only while busy is low, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_stage_divider_search #(
	parameter int MAIN_BITS = tdds_pkg::MAIN_BITS_DEF,
	parameter int FINE_BITS = tdds_pkg::FINE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              source_rate_we,
	input  logic [tdds_pkg::RATE_W-1:0]       source_rate_wdata,
	input  logic                              start,
	output logic                              busy,
	input  logic [tdds_pkg::RATE_W-1:0]       goal_rate,
	output logic                              done,
	output logic                              found,
	output logic [tdds_pkg::MAIN_OUT_W-1:0]   main_divisor,
	output logic [tdds_pkg::FINE_OUT_W-1:0]   fine_divisor
);
	import tdds_pkg::*;

	localparam int                 CNT_W     = MAIN_BITS + 1;
	localparam logic [CNT_W-1:0]   LAST_MAIN = {1'b1, {MAIN_BITS{1'b0}}};
	localparam logic [FINE_BITS-1:0] FINE_CAP = '1;

	tdds_state_t         state_q, state_d;

	logic [RATE_W-1:0]    source_rate_q;
	logic [RATE_W-1:0]    target_q;
	logic [CNT_W-1:0]     main_q;
	logic [RATE_W-1:0]    quo_q;
	logic [FINE_BITS-1:0] fine_q;
	logic [RATE_W-1:0]    best_err_q;
	logic [CNT_W-1:0]     best_main_q;
	logic [FINE_BITS-1:0] best_fine_q;
	logic                 found_q;

	logic                 accept;
	logic                 trivial;
	logic                 bypass;
	logic                 last_main;
	logic [FINE_BITS-1:0] fine_clamp;
	logic [RATE_W-1:0]    err;
	logic                 better;

	logic                 div_start;
	logic [RATE_W-1:0]    div_dividend;
	logic [RATE_W-1:0]    div_divisor;
	logic [RATE_W-1:0]    div_quo;
	div_stat_t            div_stat;

	// Shared divider
	tdds_div #(
		.W (RATE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// Decode the start word and the candidate checks
	always_comb begin
		accept    = start && (state_q == ST_IDLE);
		bypass    = (source_rate_q == '0) || (goal_rate == '0) ||
			(goal_rate >= source_rate_q);
		trivial   = (source_rate_q != '0) && (goal_rate != '0) &&
			(goal_rate >= source_rate_q);
		last_main = (main_q == LAST_MAIN);
		if (div_quo > RATE_W'(FINE_CAP)) begin
			fine_clamp = FINE_CAP;
		end else if (div_quo == '0) begin
			fine_clamp = FINE_BITS'(1);
		end else begin
			fine_clamp = div_quo[FINE_BITS-1:0];
		end
		err    = target_q - div_quo;
		better = (div_quo <= target_q) && (err <= best_err_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = bypass ? ST_DONE : ST_QUO;
				end
			end
			ST_QUO: begin
				if (div_stat.done) begin
					state_d = ST_FINE;
				end
			end
			ST_FINE: begin
				if (div_stat.done) begin
					state_d = ST_RATE;
				end
			end
			ST_RATE: begin
				if (div_stat.done) begin
					state_d = last_main ? ST_DONE : ST_QUO;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: launch the divider
	always_comb begin
		div_start    = 1'b0;
		div_dividend = source_rate_q;
		div_divisor  = RATE_W'(1);
		busy         = (state_q != ST_IDLE);
		done         = (state_q == ST_DONE);
		case (state_q)
			ST_IDLE: begin
				div_start = accept && !bypass;
			end
			ST_QUO: begin
				div_start    = div_stat.done;
				div_dividend = div_quo;
				div_divisor  = target_q;
			end
			ST_FINE: begin
				div_start    = div_stat.done;
				div_dividend = quo_q;
				div_divisor  = RATE_W'(fine_clamp);
			end
			ST_RATE: begin
				div_start    = div_stat.done && !last_main;
				div_dividend = source_rate_q;
				div_divisor  = RATE_W'(main_q + CNT_W'(1));
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			source_rate_q <= SOURCE_RATE_RST;
			found_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (source_rate_we) begin
				source_rate_q <= source_rate_wdata;
			end
			if (accept) begin
				found_q <= trivial;
			end else if ((state_q == ST_RATE) && div_stat.done && better) begin
				found_q <= 1'b1;
			end
		end
	end

	// Search datapath: hold the target, track the best candidate
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					target_q    <= goal_rate;
					best_err_q  <= goal_rate;
					main_q      <= CNT_W'(1);
					best_main_q <= trivial ? CNT_W'(1) : '0;
					best_fine_q <= FINE_BITS'(1);
				end
			end
			ST_QUO: begin
				if (div_stat.done) begin
					quo_q <= div_quo;
				end
			end
			ST_FINE: begin
				if (div_stat.done) begin
					fine_q <= fine_clamp;
				end
			end
			ST_RATE: begin
				if (div_stat.done) begin
					main_q <= main_q + CNT_W'(1);
					if (better) begin
						best_err_q  <= err;
						best_main_q <= main_q;
						best_fine_q <= fine_q;
					end
				end
			end
			default: begin
				target_q <= target_q;
			end
		endcase
	end

	assign found        = found_q;
	assign main_divisor = MAIN_OUT_W'(best_main_q);
	assign fine_divisor = FINE_OUT_W'(best_fine_q);

	// Checks
	`ASSERT_NEVER(a_div_restart, div_start && div_stat.busy, "divider launched while busy")
	`ASSERT_CLK(a_accept_busy, start && !busy |=> busy, "start word not taken")
	`ASSERT_CLK(a_not_found,
		done && !found |-> best_main_q == '0 && best_fine_q == FINE_BITS'(1), "bad not-found result")
	`ASSERT_CLK(a_fine_nonzero, done |-> best_fine_q != '0, "fine divisor is zero")

endmodule

// ----- rtl/core/tdds_div.sv -----
// ----------------------------------------------------------------------------
// tdds_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdds_div #(
	parameter int W = tdds_pkg::RATE_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [W-1:0]          dividend,
	input  logic [W-1:0]          divisor,
	output logic [W-1:0]          quotient,
	output tdds_pkg::div_stat_t   stat
);
	import tdds_pkg::*;

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [W:0]       partial;
	logic [W:0]       diff;
	logic             qbit;

	// Shift in the next dividend bit and try the subtraction.
	always_comb begin
		partial = {rem_q, quo_q[W-1]};
		diff    = partial - {1'b0, dsr_q};
		qbit    = ~diff[W];
	end

	// Control: count the steps, pulse done after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then advance one quotient bit a cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[W-1:0] : partial[W-1:0];
			quo_q <= {quo_q[W-2:0], qbit};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
